// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define GXL_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Condition in one cycle that forces a condition in the next cycle.
`define GXL_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define GXL_ASSERT(lbl, clk, rst_n, prop)
`define GXL_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ----- design/gxl_pkg.sv -----
// Shared constants and the arctangent table for the coordinate converter.
`default_nettype none
package gxl_pkg;

	// Angles are kept internally in degrees with 16 fraction bits.
	localparam int DEG90  = 90 * 65536;
	localparam int DEG180 = 180 * 65536;
	localparam int DEG360 = 360 * 65536;

	localparam int ANG_W = 23;

	localparam int NORM_W       = 58;
	localparam int NORM_STAGES  = 3;
	localparam int CORDIC_STEPS = 24;
	localparam int ATAN_LAT     = NORM_STAGES + CORDIC_STEPS + 1;

	localparam int SQRT_STEPS = 32;

	localparam logic [31:0] SUN_OFFSET_RST = 32'd557056;

	// atan(2^-i) in degrees, 16 fraction bits.
	localparam logic [ANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
		23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
		23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
		23'd14, 23'd7, 23'd4, 23'd2, 23'd1, 23'd0
	};

endpackage
`default_nettype wire

// ----- design/galactic_xyz_to_sun_lbr.sv -----
// Top level of the galactocentric x, y, z to sun-centered l, b, r converter.
// Input stream: one beat per point, tdata holds x_pos, y_pos, z_pos as signed fixed
// point with FRAC_BITS fraction bits. Output stream: one beat per point with the
// galactic longitude and latitude in degrees and the distance in the input format.
// The cfg channel loads sun_offset, which is added to x before the conversion; it is
// always ready, and it should only be written while no point is in flight.
// An accepted input beat reaches the matching output beat through five front stages
// (offset add, magnitudes, squares, two sums), 32 stages of the bit-per-stage square
// root, 28 stages of the normalizing CORDIC arctangent units, one quadrant stage and
// the output register. Throughput is one point per cycle while output beats are taken.
// The whole pipeline moves on one enable: when the output beat is not taken, every
// stage holds, and s_axis_tready drops in the same cycle, so nothing is lost or
// repeated. Bubbles keep their place in the pipeline.
// Reset clears all valid bits and loads the sun offset with 8.5 kpc.
`default_nettype none
`include "assert_macros.svh"
module galactic_xyz_to_sun_lbr
	import gxl_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,   // x_pos[31:0], y_pos[63:32], z_pos[95:64]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata,   // longitude[24:0], latitude[48:25],
	                                    // distance[80:49], zero fill[87:81]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data        // sun_offset
);

	// Angles are formed with 16 fraction bits and then scaled to FRAC_BITS.
	localparam int LSH  = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
	localparam int RSH  = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
	localparam int HALF = (1 << RSH) >> 1;
	localparam int SC_W = 26 + LSH;
	localparam longint FULL_L = ((longint'(DEG360) << LSH) + longint'(HALF)) >> RSH;
	localparam logic [SC_W-1:0] FULL_SC = SC_W'(FULL_L);

	localparam int REM_W = 35;
	localparam int SQ_N  = SQRT_STEPS;
	localparam int VLD_N = 5 + SQ_N + ATAN_LAT + 1;

	typedef struct packed {
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] az;
		logic        xneg;
		logic        yneg;
		logic        zneg;
	} sq_sb_t;

	typedef struct packed {
		logic [31:0] rdist;
		logic        xneg;
		logic        yneg;
		logic        zneg;
	} at_sb_t;

	logic adv;

	logic [31:0] sun_offset_q;
	logic [VLD_N-1:0] vld_q;
	logic        out_vld_q;

	logic [31:0] xs_s1, y_s1, z_s1;
	sq_sb_t      sb_s2;
	logic [63:0] xx_s3, yy_s3, zz_s3;
	sq_sb_t      sb_s3;
	logic [63:0] sxy_s4, zz_s4;
	sq_sb_t      sb_s4;
	logic [63:0] r_s5 [2];
	sq_sb_t      sb_s5;

	logic [31:0]      root_s [SQ_N][2];
	logic [REM_W-1:0] rem_s  [SQ_N-1][2];
	logic [63:0]      rad_s  [SQ_N-1][2];
	sq_sb_t           sb_sq_s [SQ_N];

	at_sb_t           sb_at_s [ATAN_LAT];
	logic [ANG_W-1:0] lon_ang, lat_ang;

	logic [24:0]      lon_s6;
	logic [ANG_W-1:0] latm_s6;
	logic             zneg_s6;
	logic [31:0]      dist_s6;

	logic [24:0] out_lon_q;
	logic [23:0] out_lat_q;
	logic [31:0] out_dist_q;

	// The pipeline advances whenever the output register is empty or being taken.
	assign adv           = !out_vld_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sun_offset_q <= SUN_OFFSET_RST;
		end else if (cfg_valid) begin
			sun_offset_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[VLD_N-2:0], s_axis_tvalid};
			out_vld_q <= vld_q[VLD_N-1];
		end
	end

	// Front end: saturating offset add, magnitudes, squares and sums of squares.
	logic [32:0] xsum;
	logic [31:0] xs_sat;
	sq_sb_t      sb_n2;

	assign xsum = {s_axis_tdata[31], s_axis_tdata[31:0]} + {sun_offset_q[31], sun_offset_q};

	always_comb begin
		if (xsum[32] != xsum[31]) begin
			xs_sat = xsum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			xs_sat = xsum[31:0];
		end
	end

	always_comb begin
		sb_n2.ax   = xs_s1[31] ? (~xs_s1 + 32'd1) : xs_s1;
		sb_n2.ay   = y_s1[31] ? (~y_s1 + 32'd1) : y_s1;
		sb_n2.az   = z_s1[31] ? (~z_s1 + 32'd1) : z_s1;
		sb_n2.xneg = xs_s1[31];
		sb_n2.yneg = y_s1[31];
		sb_n2.zneg = z_s1[31];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xs_s1   <= xs_sat;
			y_s1    <= s_axis_tdata[63:32];
			z_s1    <= s_axis_tdata[95:64];
			sb_s2   <= sb_n2;
			xx_s3   <= 64'(sb_s2.ax) * 64'(sb_s2.ax);
			yy_s3   <= 64'(sb_s2.ay) * 64'(sb_s2.ay);
			zz_s3   <= 64'(sb_s2.az) * 64'(sb_s2.az);
			sb_s3   <= sb_s2;
			sxy_s4  <= xx_s3 + yy_s3;
			zz_s4   <= zz_s3;
			sb_s4   <= sb_s3;
			r_s5[0] <= sxy_s4;
			r_s5[1] <= sxy_s4 + zz_s4;
			sb_s5   <= sb_s4;
		end
	end

	// Two restoring square roots side by side, one result bit per stage: channel 0
	// gives the planar radius, channel 1 the distance.
	for (genvar j = 0; j < SQ_N; j++) begin : g_sq
		for (genvar c = 0; c < 2; c++) begin : g_ch
			logic [REM_W-1:0] rem_in, rem_sh, trial, rem_n;
			logic [31:0]      root_in, root_n;
			logic [63:0]      rad_in;

			if (j == 0) begin : g_in
				assign rem_in  = '0;
				assign root_in = '0;
				assign rad_in  = r_s5[c];
			end else begin : g_prev
				assign rem_in  = rem_s[j-1][c];
				assign root_in = root_s[j-1][c];
				assign rad_in  = rad_s[j-1][c];
			end

			assign rem_sh = {rem_in[REM_W-3:0], rad_in[63:62]};
			assign trial  = REM_W'({root_in, 2'b01});

			always_comb begin
				if (rem_sh >= trial) begin
					rem_n  = rem_sh - trial;
					root_n = {root_in[30:0], 1'b1};
				end else begin
					rem_n  = rem_sh;
					root_n = {root_in[30:0], 1'b0};
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					root_s[j][c] <= root_n;
				end
			end

			if (j < SQ_N - 1) begin : g_carry
				always_ff @(posedge clk) begin
					if (adv) begin
						rem_s[j][c] <= rem_n;
						rad_s[j][c] <= {rad_in[61:0], 2'b00};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (j == 0) begin
					sb_sq_s[j] <= sb_s5;
				end else begin
					sb_sq_s[j] <= sb_sq_s[(j == 0) ? 0 : j - 1];
				end
			end
		end
	end

	// Longitude from (|xs|, |y|), latitude from (radius, |z|).
	gxl_atan u_lon_atan (
		.clk (clk),
		.en  (adv),
		.a   (sb_sq_s[SQ_N-1].ax),
		.b   (sb_sq_s[SQ_N-1].ay),
		.ang (lon_ang)
	);

	gxl_atan u_lat_atan (
		.clk (clk),
		.en  (adv),
		.a   (root_s[SQ_N-1][0]),
		.b   (sb_sq_s[SQ_N-1].az),
		.ang (lat_ang)
	);

	// Signs and distance travel alongside the arctangent units.
	for (genvar k = 0; k < ATAN_LAT; k++) begin : g_atd
		always_ff @(posedge clk) begin
			if (adv) begin
				if (k == 0) begin
					sb_at_s[k].rdist <= root_s[SQ_N-1][1];
					sb_at_s[k].xneg  <= sb_sq_s[SQ_N-1].xneg;
					sb_at_s[k].yneg  <= sb_sq_s[SQ_N-1].yneg;
					sb_at_s[k].zneg  <= sb_sq_s[SQ_N-1].zneg;
				end else begin
					sb_at_s[k] <= sb_at_s[(k == 0) ? 0 : k - 1];
				end
			end
		end
	end

	// Quadrant placement of the longitude, then the wrap of a full circle to zero.
	at_sb_t      sb_at;
	logic [25:0] lon_raw, lon_w;

	assign sb_at = sb_at_s[ATAN_LAT-1];

	always_comb begin
		unique case ({sb_at.xneg, sb_at.yneg})
			2'b00: lon_raw = 26'(lon_ang);
			2'b10: lon_raw = 26'(DEG180) - 26'(lon_ang);
			2'b11: lon_raw = 26'(DEG180) + 26'(lon_ang);
			2'b01: lon_raw = 26'(DEG360) - 26'(lon_ang);
		endcase
		lon_w = (lon_raw >= 26'(DEG360)) ? (lon_raw - 26'(DEG360)) : lon_raw;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lon_s6  <= lon_w[24:0];
			latm_s6 <= lat_ang;
			zneg_s6 <= sb_at.zneg;
			dist_s6 <= sb_at.rdist;
		end
	end

	// Scaling to FRAC_BITS with rounding half up on the magnitude.
	logic [SC_W-1:0] lon_sc, lon_f, lat_sc, lat_v;

	always_comb begin
		lon_sc = ((SC_W'(lon_s6) << LSH) + SC_W'(HALF)) >> RSH;
		lon_f  = (lon_sc >= FULL_SC) ? (lon_sc - FULL_SC) : lon_sc;
		lat_sc = ((SC_W'(latm_s6) << LSH) + SC_W'(HALF)) >> RSH;
		lat_v  = zneg_s6 ? (~lat_sc + SC_W'(1)) : lat_sc;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_lon_q  <= lon_f[24:0];
			out_lat_q  <= lat_v[23:0];
			out_dist_q <= dist_s6;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {7'b0, out_dist_q, out_lat_q, out_lon_q};

	`GXL_ASSERT(a_lon_below_circle, clk, arst_n, !vld_q[VLD_N-1] || (lon_s6 < 25'(DEG360)))
	`GXL_ASSERT(a_lat_in_range, clk, arst_n, !vld_q[VLD_N-1] || (latm_s6 <= ANG_W'(DEG90)))
	`GXL_ASSERT_NEXT(a_stall_holds, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(vld_q))
	`GXL_ASSERT_NEXT(a_accept_enters, clk, arst_n, s_axis_tvalid && s_axis_tready, vld_q[0])

endmodule
`default_nettype wire

// ----- design/gxl_atan.sv -----
// Pipelined first-quadrant arctangent: normalization followed by CORDIC vectoring.
`default_nettype none
module gxl_atan
	import gxl_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [31:0]      a,
	input  logic [31:0]      b,
	output logic [ANG_W-1:0] ang
);

	localparam int NW = NORM_W;
	localparam int XW = 64;
	localparam int GW = ANG_W + 2;

	logic [NW-1:0]        na_s  [NORM_STAGES];
	logic [NW-1:0]        nb_s  [NORM_STAGES];
	logic [NW-1:0]        nm_s  [NORM_STAGES-1];
	logic                 bz_s  [NORM_STAGES];
	logic                 az_s  [NORM_STAGES];
	logic signed [XW-1:0] x_s   [CORDIC_STEPS-1];
	logic signed [XW-1:0] y_s   [CORDIC_STEPS-1];
	logic signed [GW-1:0] g_s   [CORDIC_STEPS];
	logic                 cbz_s [CORDIC_STEPS];
	logic                 caz_s [CORDIC_STEPS];
	logic [ANG_W-1:0]     ang_q;

	// Each stage shifts both operands left while the larger one stays below bit 57.
	for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
		localparam int KH = 1 << (5 - 2 * j);
		localparam int KL = 1 << (4 - 2 * j);
		logic [NW-1:0] pa, pb, pm, ta, tb, tm;
		logic          pbz, paz;

		if (j == 0) begin : g_in
			assign pa  = {{(NW-32){1'b0}}, a};
			assign pb  = {{(NW-32){1'b0}}, b};
			assign pm  = (a > b) ? pa : pb;
			assign pbz = (b == '0);
			assign paz = (a == '0);
		end else begin : g_prev
			assign pa  = na_s[j-1];
			assign pb  = nb_s[j-1];
			assign pm  = nm_s[j-1];
			assign pbz = bz_s[j-1];
			assign paz = az_s[j-1];
		end

		always_comb begin
			ta = pa;
			tb = pb;
			tm = pm;
			if (tm[NW-1 -: KH] == '0) begin
				ta = ta << KH;
				tb = tb << KH;
				tm = tm << KH;
			end
			if (tm[NW-1 -: KL] == '0) begin
				ta = ta << KL;
				tb = tb << KL;
				tm = tm << KL;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				na_s[j] <= ta;
				nb_s[j] <= tb;
				bz_s[j] <= pbz;
				az_s[j] <= paz;
			end
		end

		if (j < NORM_STAGES - 1) begin : g_keep_max
			always_ff @(posedge clk) begin
				if (en) begin
					nm_s[j] <= tm;
				end
			end
		end
	end

	// One vectoring rotation per stage.
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		logic signed [XW-1:0] xi, yi;
		logic signed [GW-1:0] gi, gn, tab;
		logic                 fbz, faz;

		if (i == 0) begin : g_in
			assign xi  = signed'(XW'(na_s[NORM_STAGES-1]));
			assign yi  = signed'(XW'(nb_s[NORM_STAGES-1]));
			assign gi  = '0;
			assign fbz = bz_s[NORM_STAGES-1];
			assign faz = az_s[NORM_STAGES-1];
		end else begin : g_prev
			assign xi  = x_s[i-1];
			assign yi  = y_s[i-1];
			assign gi  = g_s[i-1];
			assign fbz = cbz_s[i-1];
			assign faz = caz_s[i-1];
		end

		assign tab = signed'(GW'(ATAN_TAB[i]));
		assign gn  = yi[XW-1] ? (gi - tab) : (gi + tab);

		always_ff @(posedge clk) begin
			if (en) begin
				g_s[i]   <= gn;
				cbz_s[i] <= fbz;
				caz_s[i] <= faz;
			end
		end

		if (i < CORDIC_STEPS - 1) begin : g_xy
			logic signed [XW-1:0] xn, yn;

			always_comb begin
				if (!yi[XW-1]) begin
					xn = xi + (yi >>> i);
					yn = yi - (xi >>> i);
				end else begin
					xn = xi - (yi >>> i);
					yn = yi + (xi >>> i);
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					x_s[i] <= xn;
					y_s[i] <= yn;
				end
			end
		end
	end

	// Special cases first, then the angle is clamped into the first quadrant.
	always_ff @(posedge clk) begin
		if (en) begin
			priority if (cbz_s[CORDIC_STEPS-1]) begin
				ang_q <= '0;
			end else if (caz_s[CORDIC_STEPS-1]) begin
				ang_q <= ANG_W'(DEG90);
			end else if (g_s[CORDIC_STEPS-1][GW-1]) begin
				ang_q <= '0;
			end else if (g_s[CORDIC_STEPS-1] > signed'(GW'(DEG90))) begin
				ang_q <= ANG_W'(DEG90);
			end else begin
				ang_q <= g_s[CORDIC_STEPS-1][ANG_W-1:0];
			end
		end
	end

	assign ang = ang_q;

endmodule
`default_nettype wire
